// ===== hw/rtl/shg_pkg.sv =====
package shg_pkg;

	// sizes that the ports and the memories follow
	localparam int MAX_POINTS   = 1024;
	localparam int MAX_CELLS    = 256;
	localparam int BUCKET_DEPTH = 16;
	localparam int NBUCKETS     = 4;

	localparam int PIDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W   = PIDX_W + 1;
	localparam int KEY_W   = $clog2(MAX_CELLS);
	localparam int SLOT_W  = $clog2(BUCKET_DEPTH);
	localparam int FILL_W  = SLOT_W + 1;
	localparam int EADDR_W = KEY_W + SLOT_W;
	localparam int GRID_W  = 5;
	localparam int WRAP_W  = 4;

	// actions
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_STORE_FULL  = 2'd1;
	localparam logic [1:0] ST_BUCKET_FULL = 2'd2;

	// register indexes
	localparam logic [1:0] REG_INV_CELL = 2'd0;
	localparam logic [1:0] REG_CELLS_X  = 2'd1;
	localparam logic [1:0] REG_CELLS_Y  = 2'd2;

	localparam logic [31:0]       INV_CELL_RST = 32'd65536;
	localparam logic [GRID_W-1:0] CELLS_RST    = 5'd16;

	// four bucket keys: own cell, y neighbor, x neighbor, diagonal
	typedef struct packed {
		logic [NBUCKETS-1:0][KEY_W-1:0] k;
	} keys_t;

	// grid size of 0 acts as 1, above 16 acts as 16
	function automatic logic [GRID_W-1:0] eff_cells(logic [GRID_W-1:0] c);
		logic [GRID_W-1:0] r;
		if (c == '0) begin
			r = 5'd1;
		end else if (c > 5'd16) begin
			r = 5'd16;
		end else begin
			r = c;
		end
		return r;
	endfunction

	// eight msb-first remainder steps, r stays below n
	function automatic logic [WRAP_W-1:0] mod_step8(logic [WRAP_W-1:0] r_in,
			logic [7:0] bits, logic [GRID_W-1:0] n);
		logic [WRAP_W-1:0] r;
		logic [GRID_W-1:0] t;
		r = r_in;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= n) begin
				t = t - n;
			end
			r = t[WRAP_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/shg_ram.sv =====
module shg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/shg_keys.sv =====
module shg_keys (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic [31:0]               inv_cell_size,
	input  logic [4:0]                cells_x,
	input  logic [4:0]                cells_y,
	output logic                      done,
	output shg_pkg::keys_t            keys
);
	import shg_pkg::*;

	typedef enum logic [3:0] {
		KS_IDLE = 4'b0001,
		KS_MUL  = 4'b0010,
		KS_MOD  = 4'b0100,
		KS_KEY  = 4'b1000
	} ks_state_t;

	ks_state_t         state_q;
	logic signed [31:0] px_q, py_q;
	logic [31:0]        inv_q;
	logic [GRID_W-1:0]  nx_q, ny_q;
	logic [31:0]        cx_q, cy_q;
	logic               ux_q, uy_q;
	logic [WRAP_W-1:0]  rx_q, ry_q;
	logic [1:0]         cnt_q;
	logic               done_q;
	keys_t              keys_q;

	logic signed [64:0] prod_x, prod_y;
	logic [WRAP_W-1:0]  nx_m1, ny_m1, wx2, wy2;

	// signed position times unsigned reciprocal, exact Q32.32
	assign prod_x = px_q * $signed({1'b0, inv_q});
	assign prod_y = py_q * $signed({1'b0, inv_q});
	assign nx_m1  = WRAP_W'(nx_q - 5'd1);
	assign ny_m1  = WRAP_W'(ny_q - 5'd1);

	// neighbor toward the nearer half-cell side, wrapped
	always_comb begin
		if (ux_q) begin
			wx2 = (rx_q == nx_m1) ? '0 : WRAP_W'(rx_q + 4'd1);
		end else begin
			wx2 = (rx_q == '0) ? nx_m1 : WRAP_W'(rx_q - 4'd1);
		end
		if (uy_q) begin
			wy2 = (ry_q == ny_m1) ? '0 : WRAP_W'(ry_q + 4'd1);
		end else begin
			wy2 = (ry_q == '0) ? ny_m1 : WRAP_W'(ry_q - 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				KS_IDLE: begin
					if (start) begin
						state_q <= KS_MUL;
					end
				end
				KS_MUL: begin
					cnt_q   <= '0;
					state_q <= KS_MOD;
				end
				KS_MOD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= KS_KEY;
					end
				end
				KS_KEY: begin
					done_q  <= 1'b1;
					state_q <= KS_IDLE;
				end
				default: state_q <= KS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			KS_IDLE: begin
				px_q  <= pos_x;
				py_q  <= pos_y;
				inv_q <= inv_cell_size;
				nx_q  <= eff_cells(cells_x);
				ny_q  <= eff_cells(cells_y);
			end
			KS_MUL: begin
				cx_q <= prod_x[63:32];
				cy_q <= prod_y[63:32];
				ux_q <= prod_x[31];
				uy_q <= prod_y[31];
				// a negative cell starts from -1 mod n
				rx_q <= prod_x[63] ? nx_m1 : '0;
				ry_q <= prod_y[63] ? ny_m1 : '0;
			end
			KS_MOD: begin
				rx_q <= mod_step8(rx_q, cx_q[31:24], nx_q);
				ry_q <= mod_step8(ry_q, cy_q[31:24], ny_q);
				cx_q <= {cx_q[23:0], 8'd0};
				cy_q <= {cy_q[23:0], 8'd0};
			end
			KS_KEY: begin
				keys_q.k[0] <= KEY_W'(ry_q) * KEY_W'(nx_q) + KEY_W'(rx_q);
				keys_q.k[1] <= KEY_W'(wy2) * KEY_W'(nx_q) + KEY_W'(rx_q);
				keys_q.k[2] <= KEY_W'(ry_q) * KEY_W'(nx_q) + KEY_W'(wx2);
				keys_q.k[3] <= KEY_W'(wy2) * KEY_W'(nx_q) + KEY_W'(wx2);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign keys = keys_q;

endmodule

// ===== hw/rtl/spatial_hash_grid_neighbor_search.sv =====
// 2d point store on a wrapped uniform grid. a request is taken when start is
// high and busy is low. clear takes effect at once and gives no result. insert
// and query first pass through the key unit, which multiplies the position by
// the reciprocal and wraps the cell indices 8 bits per cycle. insert gives one
// result: the new point index, or a store-full or bucket-full status. a query
// walks four buckets and gives one result per bucket entry whose point lies
// within the radius, the last one flagged by last, or a single miss result;
// its final result comes once the scan has read every entry of the four
// buckets (up to 64 entries) and the distance pipeline has drained; the scan
// reads one entry of the bucket memory per cycle. results come as one-cycle
// strobes and cannot be stalled, so a receiver must take every cycle that
// strobe is high. configuration writes are always ready and must be done
// while not busy.
module spatial_hash_grid_neighbor_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        radius,
	output logic               strobe,
	output logic [9:0]         point_index,
	output logic               hit,
	output logic [1:0]         status,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import shg_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_KEYS  = 6'b000010,
		S_FILL  = 6'b000100,
		S_INS   = 6'b001000,
		S_SCAN  = 6'b010000,
		S_DRAIN = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0]       inv_cell_q;
	logic [GRID_W-1:0] cells_x_q, cells_y_q;

	// request payload
	logic [1:0]         action_q;
	logic signed [31:0] qx_q, qy_q;
	logic [61:0]        r2_q;
	keys_t              keys_q;

	// key unit
	logic  keys_start, keys_done;
	keys_t keys_w;

	// store bookkeeping
	logic [CNT_W-1:0]     count_q;
	logic [MAX_CELLS-1:0] fvalid_q;
	logic [NBUCKETS-1:0][FILL_W-1:0] fills_q;
	logic [1:0]           fcnt_q;
	logic                 frd_s1, fv_s1;
	logic [1:0]           fidx_s1;

	// scan control
	logic [1:0]        b_q;
	logic [FILL_W-1:0] j_q;
	logic              iss;

	// scan pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [PIDX_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [31:0]       ax_s3, ay_s3;
	logic [63:0]       dx2_s4, dy2_s4;
	logic              pend_v_q;
	logic [PIDX_W-1:0] pend_idx_q;

	// output register
	logic              strobe_q, hit_q, last_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [1:0]        status_q;

	// memory ports
	logic               fill_we;
	logic [KEY_W-1:0]   fill_waddr, fill_raddr;
	logic [FILL_W-1:0]  fill_wdata, fill_rdata, fill_data;
	logic               ent_we;
	logic [EADDR_W-1:0] ent_waddr, ent_raddr;
	logic [PIDX_W-1:0]  ent_rdata;
	logic               pt_we;
	logic [63:0]        pt_rdata;

	logic               accept, ins_ok, pipe_busy, match;
	logic [FILL_W-1:0]  cur_fill;
	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	logic [64:0]        dist2;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign keys_start = accept && (action == ACT_INSERT || action == ACT_QUERY);

	shg_keys u_keys (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (keys_start),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.inv_cell_size (inv_cell_q),
		.cells_x       (cells_x_q),
		.cells_y       (cells_y_q),
		.done          (keys_done),
		.keys          (keys_w)
	);

	// bucket fill counts; an entry without its valid bit reads as zero
	assign fill_raddr = keys_q.k[fcnt_q];
	assign fill_data  = fv_s1 ? fill_rdata : '0;
	assign ins_ok     = (count_q < CNT_W'(MAX_POINTS)) &&
	                    (fill_data < FILL_W'(BUCKET_DEPTH));
	assign fill_we    = (state_q == S_INS) && ins_ok;
	assign fill_waddr = keys_q.k[0];
	assign fill_wdata = FILL_W'(fill_data + 5'd1);

	shg_ram #(.WIDTH(FILL_W), .DEPTH(MAX_CELLS)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	// bucket entries, one row of slots per key
	assign ent_we    = fill_we;
	assign ent_waddr = {keys_q.k[0], fill_data[SLOT_W-1:0]};
	assign ent_raddr = {keys_q.k[b_q], j_q[SLOT_W-1:0]};

	shg_ram #(.WIDTH(PIDX_W), .DEPTH(MAX_CELLS * BUCKET_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (count_q[PIDX_W-1:0]),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// point coordinates, x in the upper half
	assign pt_we = fill_we;

	shg_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[PIDX_W-1:0]),
		.wdata ({qx_q, qy_q}),
		.raddr (ent_rdata),
		.rdata (pt_rdata)
	);

	// scan issue: one entry read per cycle; past a bucket's last entry the scan moves to the next bucket without a read
	assign cur_fill = fills_q[b_q];
	assign iss      = (state_q == S_SCAN) && (j_q < cur_fill);

	// distance check pipeline
	assign dx    = $signed({pt_rdata[63], pt_rdata[63:32]}) - $signed({qx_q[31], qx_q});
	assign dy    = $signed({pt_rdata[31], pt_rdata[31:0]}) - $signed({qy_q[31], qy_q});
	assign adx   = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady   = dy[32] ? 33'(-dy) : 33'(dy);
	assign dist2 = 65'(dx2_s4) + 65'(dy2_s4);
	assign match = v_s4 && (dist2 <= 65'(r2_q));

	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			inv_cell_q <= INV_CELL_RST;
			cells_x_q  <= CELLS_RST;
			cells_y_q  <= CELLS_RST;
			count_q    <= '0;
			fvalid_q   <= '0;
			fcnt_q     <= '0;
			frd_s1     <= 1'b0;
			b_q        <= '0;
			j_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			pend_v_q   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			frd_s1   <= (state_q == S_FILL);
			v_s1     <= iss;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_INV_CELL: inv_cell_q <= cfg_data;
					REG_CELLS_X:  cells_x_q  <= cfg_data[GRID_W-1:0];
					REG_CELLS_Y:  cells_y_q  <= cfg_data[GRID_W-1:0];
					default: ;
				endcase
			end

			// a match is held back one result so the final one can carry last
			if (match) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					strobe_q <= 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_CLEAR) begin
							count_q  <= '0;
							fvalid_q <= '0;
						end else if (keys_start) begin
							state_q <= S_KEYS;
						end
					end
				end
				S_KEYS: begin
					fcnt_q   <= '0;
					pend_v_q <= 1'b0;
					if (keys_done) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (action_q == ACT_INSERT) begin
						state_q <= S_INS;
					end else if (fcnt_q == 2'd3) begin
						b_q     <= '0;
						j_q     <= '0;
						state_q <= S_SCAN;
					end else begin
						fcnt_q <= fcnt_q + 2'd1;
					end
				end
				S_INS: begin
					strobe_q <= 1'b1;
					if (ins_ok) begin
						count_q                <= count_q + 1'b1;
						fvalid_q[keys_q.k[0]] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (iss) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						if (b_q == 2'd3) begin
							state_q <= S_DRAIN;
						end else begin
							b_q <= b_q + 2'd1;
						end
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fv_s1   <= fvalid_q[fill_raddr];
		fidx_s1 <= fcnt_q;
		if (frd_s1) begin
			fills_q[fidx_s1] <= fill_data;
		end

		if (accept) begin
			action_q <= action;
			qx_q     <= pos_x;
			qy_q     <= pos_y;
			r2_q     <= 62'(radius) * 62'(radius);
		end
		if (keys_done) begin
			keys_q <= keys_w;
		end

		idx_s2 <= ent_rdata;
		ax_s3  <= adx[31:0];
		ay_s3  <= ady[31:0];
		idx_s3 <= idx_s2;
		dx2_s4 <= 64'(ax_s3) * 64'(ax_s3);
		dy2_s4 <= 64'(ay_s3) * 64'(ay_s3);
		idx_s4 <= idx_s3;

		if (match) begin
			pend_idx_q <= idx_s4;
			pidx_q     <= pend_idx_q;
			hit_q      <= 1'b1;
			status_q   <= ST_OK;
			last_q     <= 1'b0;
		end

		if (state_q == S_INS) begin
			last_q <= 1'b1;
			if (count_q >= CNT_W'(MAX_POINTS)) begin
				pidx_q   <= '0;
				hit_q    <= 1'b0;
				status_q <= ST_STORE_FULL;
			end else if (!ins_ok) begin
				pidx_q   <= '0;
				hit_q    <= 1'b0;
				status_q <= ST_BUCKET_FULL;
			end else begin
				pidx_q   <= count_q[PIDX_W-1:0];
				hit_q    <= 1'b1;
				status_q <= ST_OK;
			end
		end

		// end of a query: the held match, or a miss
		if (state_q == S_DRAIN && !pipe_busy) begin
			last_q   <= 1'b1;
			status_q <= ST_OK;
			hit_q    <= pend_v_q;
			pidx_q   <= pend_v_q ? pend_idx_q : '0;
		end
	end

	assign strobe      = strobe_q;
	assign point_index = pidx_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule
